FILE: rtl/rlps_pkg.sv
package rlps_pkg;

    typedef enum logic [1:0] {
        PAT_OFF   = 2'd0,
        PAT_WARM  = 2'd1,
        PAT_GREEN = 2'd2,
        PAT_FLASH = 2'd3
    } t_pattern;

    typedef enum logic [2:0] {
        REG_PULSE_HALF  = 3'd0,
        REG_GREEN_ON    = 3'd1,
        REG_GREEN_OFF   = 3'd2,
        REG_FLASH_HALF  = 3'd3,
        REG_FLASH_TOGS  = 3'd4,
        REG_RETURN_GAP  = 3'd5
    } t_reg_index;

    localparam int unsigned DLY_W  = 16;
    localparam int unsigned STEP_W = 3;

    localparam logic [DLY_W-1:0]  RST_PULSE_HALF = 16'd250;
    localparam logic [DLY_W-1:0]  RST_GREEN_ON   = 16'd700;
    localparam logic [DLY_W-1:0]  RST_GREEN_OFF  = 16'd300;
    localparam logic [DLY_W-1:0]  RST_FLASH_HALF = 16'd100;
    localparam logic [STEP_W-1:0] RST_FLASH_TOGS = 3'd6;
    localparam logic [DLY_W-1:0]  RST_RETURN_GAP = 16'd200;

    // LED level vector: bit 0 red, bit 1 green, bit 2 blue.
    localparam int unsigned LED_R = 0;
    localparam int unsigned LED_G = 1;
    localparam int unsigned LED_B = 2;

endpackage

FILE: rtl/rgb_led_pattern_sequencer.sv
// Each accepted item's result is registered straight into the output register.
// Throughput: one item per cycle; the whole state update is one combinational pass
// from the state registers and the input fields into the state and result registers.
// The input is stalled only while a result waits in the output register and is stalled.
// Synchronous active-low reset: pattern off, timer disarmed, LEDs off, registers
// back to their default intervals.
module rgb_led_pattern_sequencer
    import rlps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [1:0]  i_new_pattern,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_red_on,
    output logic        o_green_on,
    output logic        o_blue_on,
    output logic [1:0]  o_pattern_now
);

    logic [DLY_W-1:0]  r_pulse_half;
    logic [DLY_W-1:0]  r_green_on;
    logic [DLY_W-1:0]  r_green_off;
    logic [DLY_W-1:0]  r_flash_half;
    logic [STEP_W-1:0] r_flash_togs;
    logic [DLY_W-1:0]  r_return_gap;

    t_pattern          r_pattern, n_pattern;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DLY_W-1:0]  r_delay, n_delay;
    logic              r_armed, n_armed;
    logic [2:0]        r_leds, n_leds;

    logic              r_out_valid;
    logic [2:0]        r_out_leds;
    t_pattern          r_out_pattern;

    logic              w_accept;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_half <= RST_PULSE_HALF;
            r_green_on   <= RST_GREEN_ON;
            r_green_off  <= RST_GREEN_OFF;
            r_flash_half <= RST_FLASH_HALF;
            r_flash_togs <= RST_FLASH_TOGS;
            r_return_gap <= RST_RETURN_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PULSE_HALF: r_pulse_half <= i_cfg_data;
                REG_GREEN_ON:   r_green_on   <= i_cfg_data;
                REG_GREEN_OFF:  r_green_off  <= i_cfg_data;
                REG_FLASH_HALF: r_flash_half <= i_cfg_data;
                REG_FLASH_TOGS: r_flash_togs <= i_cfg_data[STEP_W-1:0];
                REG_RETURN_GAP: r_return_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic run;
        run       = 1'b0;
        n_pattern = r_pattern;
        n_step    = r_step;
        n_delay   = r_delay;
        n_armed   = r_armed;
        n_leds    = r_leds;

        if (i_req_type) begin
            n_pattern = t_pattern'(i_new_pattern);
            n_step    = '0;
            n_delay   = '0;
            n_armed   = 1'b0;
            n_leds    = '0;
            run       = 1'b1;
        end else if (r_armed) begin
            // A loaded delay of zero expires on the next tick, like a delay of one.
            if (r_delay <= DLY_W'(1)) begin
                n_delay = '0;
                run     = 1'b1;
            end else begin
                n_delay = r_delay - DLY_W'(1);
            end
        end

        if (run) begin
            unique case (n_pattern)
                PAT_OFF: begin
                    n_leds  = '0;
                    n_armed = 1'b0;
                    n_delay = '0;
                end
                PAT_WARM: begin
                    n_leds[LED_R] = n_step[0];
                    n_step        = n_step + STEP_W'(1);
                    n_delay       = r_pulse_half;
                    n_armed       = 1'b1;
                end
                PAT_GREEN: begin
                    n_leds[LED_G] = ~n_step[0];
                    n_delay       = n_step[0] ? r_green_off : r_green_on;
                    n_step        = n_step + STEP_W'(1);
                    n_armed       = 1'b1;
                end
                PAT_FLASH: begin
                    if (n_step < r_flash_togs) begin
                        n_leds[LED_B] = n_step[0];
                        n_step        = n_step + STEP_W'(1);
                        n_delay       = r_flash_half;
                    end else begin
                        // Flash is done: fall back to green breathe after the gap.
                        n_leds[LED_B] = 1'b0;
                        n_pattern     = PAT_GREEN;
                        n_step        = '0;
                        n_delay       = r_return_gap;
                    end
                    n_armed = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PAT_OFF;
            r_step    <= '0;
            r_delay   <= '0;
            r_armed   <= 1'b0;
            r_leds    <= '0;
        end else if (w_accept) begin
            r_pattern <= n_pattern;
            r_step    <= n_step;
            r_delay   <= n_delay;
            r_armed   <= n_armed;
            r_leds    <= n_leds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_leds    <= n_leds;
            r_out_pattern <= n_pattern;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_red_on      = r_out_leds[LED_R];
    assign o_green_on    = r_out_leds[LED_G];
    assign o_blue_on     = r_out_leds[LED_B];
    assign o_pattern_now = r_out_pattern;

`ifndef SYNTHESIS
    // The off pattern is only entered through reset or a request, both of which clear everything.
    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern == PAT_OFF |-> (r_leds == 3'b000) && !r_armed)
        else $error("off pattern with LEDs lit or timer armed");

    a_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern != PAT_OFF |-> r_armed)
        else $error("running pattern with timer disarmed");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_req_type && !r_armed |=>
            $stable(r_leds) && $stable(r_pattern) && $stable(r_step))
        else $error("tick while disarmed changed the state");

    a_green_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern == PAT_GREEN |-> !r_leds[LED_R] && !r_leds[LED_B])
        else $error("green breathe with red or blue lit");
`endif

endmodule
